@@ hdl/rth_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rth_pkg;

   // Default widths
   localparam int DEFAULT_COLOR_BITS    = 8;
   localparam int DEFAULT_HUE_FRAC_BITS = 6;

   // Hue constants in whole degrees
   localparam int DEG_SEXTANT = 60;
   localparam int DEG_GREEN   = 120;
   localparam int DEG_BLUE    = 240;
   localparam int DEG_FULL    = 360;

   // Which component is largest (ties: red, then green)
   typedef enum logic [1:0] {
      SEL_RED   = 2'd0,
      SEL_GREEN = 2'd1,
      SEL_BLUE  = 2'd2
   } sextant_type;

   // Per-item control that travels beside the dividers
   typedef struct packed {
      sextant_type sel;
      logic        hue_neg;
      logic        chroma_zero;
      logic        value_zero;
   } rth_ctrl_type;

endpackage

`default_nettype wire

@@ hdl/rth_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rth_front
   import rth_pkg::*;
#(
   parameter int COLOR_BITS    = DEFAULT_COLOR_BITS,
   parameter int HUE_FRAC_BITS = DEFAULT_HUE_FRAC_BITS,
   localparam int HW = COLOR_BITS + 6 + HUE_FRAC_BITS,
   localparam int SW = 2 * COLOR_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [COLOR_BITS-1:0] red,
   input  wire logic [COLOR_BITS-1:0] green,
   input  wire logic [COLOR_BITS-1:0] blue,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [HW-1:0]              hue_num,
   output logic [COLOR_BITS-1:0]      chroma,
   output logic [SW-1:0]              sat_num,
   output logic [COLOR_BITS-1:0]      value,
   output rth_ctrl_type               ctrl
);

   localparam int CB = COLOR_BITS;

   // Stage 1: max, min and sextant select
   logic          v1_ff;
   logic [CB-1:0] r1_ff, g1_ff, b1_ff, mx1_ff, mn1_ff;
   logic [CB-1:0] mx1_in, mn1_in;
   sextant_type   sel1_ff, sel1_in;

   // Stage 2: chroma, sextant difference and dividends
   logic          v2_ff;
   logic [HW-1:0] hnum2_ff, hnum2_in;
   logic [SW-1:0] snum2_ff, snum2_in;
   logic [CB-1:0] c2_ff, c2_in, mx2_ff;
   rth_ctrl_type  ctrl2_ff, ctrl2_in;

   logic en1, en2;
   logic signed [CB:0] diff;
   logic [CB-1:0]      mag;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // Largest and smallest component
   always_comb begin
      if (red >= green && red >= blue) begin
         sel1_in = SEL_RED;
         mx1_in  = red;
      end else if (green >= blue) begin
         sel1_in = SEL_GREEN;
         mx1_in  = green;
      end else begin
         sel1_in = SEL_BLUE;
         mx1_in  = blue;
      end
      mn1_in = red;
      if (green < mn1_in) mn1_in = green;
      if (blue < mn1_in) mn1_in = blue;
   end

   // Chroma, signed difference, |diff| * 60 * 2^F and chroma * full scale
   always_comb begin
      c2_in = mx1_ff - mn1_ff;
      case (sel1_ff)
         SEL_RED:   diff = $signed({1'b0, g1_ff}) - $signed({1'b0, b1_ff});
         SEL_GREEN: diff = $signed({1'b0, b1_ff}) - $signed({1'b0, r1_ff});
         SEL_BLUE:  diff = $signed({1'b0, r1_ff}) - $signed({1'b0, g1_ff});
         default:   diff = '0;
      endcase
      mag      = diff[CB] ? CB'(-diff) : diff[CB-1:0];
      hnum2_in = (HW'(mag) << (6 + HUE_FRAC_BITS)) - (HW'(mag) << (2 + HUE_FRAC_BITS));
      snum2_in = (SW'(c2_in) << CB) - SW'(c2_in);
      ctrl2_in.sel         = sel1_ff;
      ctrl2_in.hue_neg     = diff[CB];
      ctrl2_in.chroma_zero = (c2_in == '0);
      ctrl2_in.value_zero  = (mx1_ff == '0);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (en1) begin
         r1_ff   <= red;
         g1_ff   <= green;
         b1_ff   <= blue;
         mx1_ff  <= mx1_in;
         mn1_ff  <= mn1_in;
         sel1_ff <= sel1_in;
      end
      if (en2) begin
         hnum2_ff <= hnum2_in;
         snum2_ff <= snum2_in;
         c2_ff    <= c2_in;
         mx2_ff   <= mx1_ff;
         ctrl2_ff <= ctrl2_in;
      end
   end

   assign out_valid = v2_ff;
   assign hue_num   = hnum2_ff;
   assign chroma    = c2_ff;
   assign sat_num   = snum2_ff;
   assign value     = mx2_ff;
   assign ctrl      = ctrl2_ff;

endmodule

`default_nettype wire

@@ hdl/rth_div_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rth_div_pipe
   import rth_pkg::*;
#(
   parameter int COLOR_BITS    = DEFAULT_COLOR_BITS,
   parameter int HUE_FRAC_BITS = DEFAULT_HUE_FRAC_BITS,
   localparam int HW = COLOR_BITS + 6 + HUE_FRAC_BITS,
   localparam int SW = 2 * COLOR_BITS,
   localparam int QH = 6 + HUE_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [HW-1:0]         hue_num,
   input  wire logic [COLOR_BITS-1:0] chroma,
   input  wire logic [SW-1:0]         sat_num,
   input  wire logic [COLOR_BITS-1:0] value,
   input  wire rth_ctrl_type          ctrl_i,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [QH-1:0]              hue_quot,
   output logic [COLOR_BITS-1:0]      sat_quot,
   output logic [COLOR_BITS-1:0]      value_o,
   output rth_ctrl_type               ctrl_o
);

   localparam int CB    = COLOR_BITS;
   localparam int DEPTH = (QH > CB) ? QH : CB;

   // One restoring step of each division per stage, both ending together
   typedef struct packed {
      logic [HW-1:0] hrem;
      logic [QH-1:0] hq;
      logic [CB-1:0] hd;
      logic [SW-1:0] srem;
      logic [CB-1:0] sq;
      logic [CB-1:0] sd;
      rth_ctrl_type  ctrl;
   } stage_type;

   stage_type stage_ff [DEPTH];
   stage_type stage_in [DEPTH];
   stage_type stage_src [DEPTH];
   logic      v_ff [DEPTH];
   logic      en [DEPTH];

   for (genvar s = 0; s < DEPTH; s++) begin : g_stage
      localparam int BIT = DEPTH - 1 - s;

      // Stage input and flow control
      if (s == 0) begin : g_first
         always_comb begin
            stage_src[s].hrem = hue_num;
            stage_src[s].hq   = '0;
            stage_src[s].hd   = chroma;
            stage_src[s].srem = sat_num;
            stage_src[s].sq   = '0;
            stage_src[s].sd   = value;
            stage_src[s].ctrl = ctrl_i;
         end
      end else begin : g_next
         assign stage_src[s] = stage_ff[s-1];
      end

      if (s == DEPTH - 1) begin : g_last_en
         assign en[s] = !v_ff[s] || out_ready;
      end else begin : g_mid_en
         assign en[s] = !v_ff[s] || en[s+1];
      end

      // Compare against shifted divisor, subtract and set quotient bit
      always_comb begin
         logic [HW-1:0] htrial;
         logic [SW-1:0] strial;
         stage_in[s] = stage_src[s];
         htrial = HW'(stage_src[s].hd) << BIT;
         strial = SW'(stage_src[s].sd) << BIT;
         if (BIT < QH && stage_src[s].hrem >= htrial) begin
            stage_in[s].hrem = stage_src[s].hrem - htrial;
            stage_in[s].hq   = stage_src[s].hq | (QH'(1) << BIT);
         end
         if (BIT < CB && stage_src[s].srem >= strial) begin
            stage_in[s].srem = stage_src[s].srem - strial;
            stage_in[s].sq   = stage_src[s].sq | (CB'(1) << BIT);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en[s]) begin
            v_ff[s] <= (s == 0) ? in_valid : v_ff[(s == 0) ? 0 : s - 1];
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[DEPTH-1];
   assign hue_quot  = stage_ff[DEPTH-1].hq;
   assign sat_quot  = stage_ff[DEPTH-1].sq;
   assign value_o   = stage_ff[DEPTH-1].sd;
   assign ctrl_o    = stage_ff[DEPTH-1].ctrl;

endmodule

`default_nettype wire

@@ hdl/rth_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rth_back
   import rth_pkg::*;
#(
   parameter int COLOR_BITS    = DEFAULT_COLOR_BITS,
   parameter int HUE_FRAC_BITS = DEFAULT_HUE_FRAC_BITS,
   localparam int QH    = 6 + HUE_FRAC_BITS,
   localparam int HUE_W = 9 + HUE_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [QH-1:0]         hue_quot,
   input  wire logic [COLOR_BITS-1:0] sat_quot,
   input  wire logic [COLOR_BITS-1:0] value,
   input  wire rth_ctrl_type          ctrl,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [HUE_W-1:0]           hue,
   output logic [COLOR_BITS-1:0]      saturation,
   output logic [COLOR_BITS-1:0]      brightness
);

   localparam int HT = HUE_W + 1;

   logic                   v_ff;
   logic [HUE_W-1:0]       hue_ff, hue_in;
   logic [COLOR_BITS-1:0]  sat_ff, sat_in, bright_ff;
   logic signed [HT-1:0]   term, offset, sum, wrapped;
   logic                   en;

   assign en       = !v_ff || out_ready;
   assign in_ready = en;

   // Sign the sextant term, add the sextant offset, wrap negatives by 360
   always_comb begin
      term = ctrl.hue_neg ? -$signed(HT'(hue_quot)) : $signed(HT'(hue_quot));
      case (ctrl.sel)
         SEL_RED:   offset = '0;
         SEL_GREEN: offset = $signed(HT'(DEG_GREEN) << HUE_FRAC_BITS);
         SEL_BLUE:  offset = $signed(HT'(DEG_BLUE) << HUE_FRAC_BITS);
         default:   offset = '0;
      endcase
      sum     = term + offset;
      wrapped = sum[HT-1] ? sum + $signed(HT'(DEG_FULL) << HUE_FRAC_BITS) : sum;
      hue_in  = ctrl.chroma_zero ? '0 : wrapped[HUE_W-1:0];
      sat_in  = ctrl.value_zero ? '0 : sat_quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (en) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= value;
      end
   end

   assign out_valid  = v_ff;
   assign hue        = hue_ff;
   assign saturation = sat_ff;
   assign brightness = bright_ff;

endmodule

`default_nettype wire

@@ hdl/rgb_to_hsv_converter.sv @@
// RGB to HSV pixel converter.
// Input channel req_*: one pixel per item, red, green and blue packed in
// req_tdata from the lowest bits up. Result channel rsp_*: hue (degrees with
// HUE_FRAC_BITS fraction bits), saturation (chroma * full scale / value,
// floored) and brightness (largest component), packed in rsp_tdata.
// Both channels transfer an item when tvalid and tready are high together.
// Throughput: one pixel per clock while rsp_tready is held high. The
// pipeline holds two restoring dividers (hue term and saturation), which
// resolve one quotient bit per pipeline stage, plus two front stages and
// the output register.
// Every stage holds its own valid bit and advances when the stage after it
// is empty or moving, so empty stages fill while the receiver stalls and
// input is taken until the whole pipeline is full; nothing is lost or
// repeated. A synchronous reset clears all valid bits; no pixel state is
// kept between items.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter
   import rth_pkg::*;
#(
   parameter int COLOR_BITS    = DEFAULT_COLOR_BITS,
   parameter int HUE_FRAC_BITS = DEFAULT_HUE_FRAC_BITS,
   localparam int HUE_W = 9 + HUE_FRAC_BITS,
   localparam int REQ_W = ((3 * COLOR_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((HUE_W + 2 * COLOR_BITS + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,   // red, green, blue
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata    // hue, saturation, brightness
);

   localparam int CB = COLOR_BITS;
   localparam int HW = CB + 6 + HUE_FRAC_BITS;
   localparam int SW = 2 * CB;
   localparam int QH = 6 + HUE_FRAC_BITS;

   logic [CB-1:0]    red, green, blue;
   logic             f_valid, f_ready, d_valid, d_ready;
   logic [HW-1:0]    hue_num;
   logic [SW-1:0]    sat_num;
   logic [CB-1:0]    chroma, f_value, d_value, sat_quot;
   logic [QH-1:0]    hue_quot;
   rth_ctrl_type     f_ctrl, d_ctrl;
   logic [HUE_W-1:0] hue;
   logic [CB-1:0]    saturation, brightness;

   assign red   = req_tdata[CB-1:0];
   assign green = req_tdata[2*CB-1:CB];
   assign blue  = req_tdata[3*CB-1:2*CB];

   // Max/min, chroma and dividends
   rth_front #(
      .COLOR_BITS   (COLOR_BITS),
      .HUE_FRAC_BITS(HUE_FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .red      (red),
      .green    (green),
      .blue     (blue),
      .out_valid(f_valid),
      .out_ready(f_ready),
      .hue_num  (hue_num),
      .chroma   (chroma),
      .sat_num  (sat_num),
      .value    (f_value),
      .ctrl     (f_ctrl)
   );

   // Pipelined hue and saturation dividers
   rth_div_pipe #(
      .COLOR_BITS   (COLOR_BITS),
      .HUE_FRAC_BITS(HUE_FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (f_valid),
      .in_ready (f_ready),
      .hue_num  (hue_num),
      .chroma   (chroma),
      .sat_num  (sat_num),
      .value    (f_value),
      .ctrl_i   (f_ctrl),
      .out_valid(d_valid),
      .out_ready(d_ready),
      .hue_quot (hue_quot),
      .sat_quot (sat_quot),
      .value_o  (d_value),
      .ctrl_o   (d_ctrl)
   );

   // Hue offset and wrap, output register
   rth_back #(
      .COLOR_BITS   (COLOR_BITS),
      .HUE_FRAC_BITS(HUE_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .hue_quot  (hue_quot),
      .sat_quot  (sat_quot),
      .value     (d_value),
      .ctrl      (d_ctrl),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .hue       (hue),
      .saturation(saturation),
      .brightness(brightness)
   );

   assign rsp_tdata = RSP_W'({brightness, saturation, hue});

endmodule

`default_nettype wire

@@ bench/rgb_to_hsv_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the RGB to HSV converter, predicts hue,
// saturation and brightness for every pixel taken in, and compares each
// result item against the oldest prediction still waiting.
module rgb_to_hsv_checker
   import rth_pkg::*;
#(
   parameter int COLOR_BITS    = DEFAULT_COLOR_BITS,
   parameter int HUE_FRAC_BITS = DEFAULT_HUE_FRAC_BITS,
   localparam int HUE_W = 9 + HUE_FRAC_BITS,
   localparam int REQ_W = ((3 * COLOR_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((HUE_W + 2 * COLOR_BITS + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,   // red, green, blue
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [RSP_W-1:0] rsp_tdata,   // hue, saturation, brightness
   output int                    fail_count,
   output int                    pending,
   output int                    pixels_seen,
   output int                    results_seen
);

   localparam int FULL_SCALE = (1 << COLOR_BITS) - 1;
   localparam int HUE_ONE    = 1 << HUE_FRAC_BITS;

   typedef struct {
      logic [HUE_W-1:0]      hue;
      logic [COLOR_BITS-1:0] saturation;
      logic [COLOR_BITS-1:0] brightness;
   } hsv_type;

   hsv_type hsv_queue[$];

   // Fixed-point HSV of one pixel
   function automatic hsv_type predict_hsv(input logic [COLOR_BITS-1:0] red,
                                           input logic [COLOR_BITS-1:0] green,
                                           input logic [COLOR_BITS-1:0] blue);
      int          ri;
      int          gi;
      int          bi;
      int          top;
      int          bottom;
      int          chroma;
      int          hue_acc;
      sextant_type sel;
      hsv_type     res;
      ri = red;
      gi = green;
      bi = blue;
      // largest component, ties go to red, then green
      top = ri;
      sel = SEL_RED;
      if (gi > top) begin
         top = gi;
         sel = SEL_GREEN;
      end
      if (bi > top) begin
         top = bi;
         sel = SEL_BLUE;
      end
      bottom = ri;
      if (gi < bottom) bottom = gi;
      if (bi < bottom) bottom = bi;
      chroma = top - bottom;

      // hue term truncates toward zero, then the sextant offset and wrap
      hue_acc = 0;
      if (chroma != 0) begin
         case (sel)
            SEL_RED:   hue_acc = (DEG_SEXTANT * (gi - bi) * HUE_ONE) / chroma;
            SEL_GREEN: hue_acc = (DEG_SEXTANT * (bi - ri) * HUE_ONE) / chroma
                                 + DEG_GREEN * HUE_ONE;
            default:   hue_acc = (DEG_SEXTANT * (ri - gi) * HUE_ONE) / chroma
                                 + DEG_BLUE * HUE_ONE;
         endcase
         if (hue_acc < 0) hue_acc += DEG_FULL * HUE_ONE;
      end

      res.hue        = hue_acc[HUE_W-1:0];
      res.saturation = (top != 0) ? COLOR_BITS'((chroma * FULL_SCALE) / top) : '0;
      res.brightness = top[COLOR_BITS-1:0];
      return res;
   endfunction

   // One line per mismatch
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("t=%0t result %0d: %s got %0d, expected %0d",
               $realtime, results_seen, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count   = 0;
      pending      = 0;
      pixels_seen  = 0;
      results_seen = 0;
   end

   // Input side: predict every pixel taken in
   always @(posedge clock) begin
      if (!reset && req_tvalid === 1'b1 && req_tready === 1'b1) begin
         hsv_queue.push_back(predict_hsv(req_tdata[COLOR_BITS-1:0],
                                         req_tdata[2*COLOR_BITS-1:COLOR_BITS],
                                         req_tdata[3*COLOR_BITS-1:2*COLOR_BITS]));
         pixels_seen++;
      end
   end

   // Result side: compare against the oldest prediction
   always @(posedge clock) begin
      hsv_type want;
      logic [HUE_W-1:0]      got_hue;
      logic [COLOR_BITS-1:0] got_sat;
      logic [COLOR_BITS-1:0] got_val;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got_hue = rsp_tdata[HUE_W-1:0];
         got_sat = rsp_tdata[HUE_W+COLOR_BITS-1:HUE_W];
         got_val = rsp_tdata[HUE_W+2*COLOR_BITS-1:HUE_W+COLOR_BITS];
         if (hsv_queue.size() == 0) begin
            report_mismatch("unexpected item, hue", got_hue, -1);
         end else begin
            want = hsv_queue.pop_front();
            if (got_hue !== want.hue) report_mismatch("hue", got_hue, want.hue);
            if (got_sat !== want.saturation)
               report_mismatch("saturation", got_sat, want.saturation);
            if (got_val !== want.brightness)
               report_mismatch("brightness", got_val, want.brightness);
         end
         results_seen++;
      end
   end

   // pending is read by the top after each edge
   always @(posedge clock) begin
      #1 pending = hsv_queue.size();
   end

endmodule

@@ bench/rgb_to_hsv_converter_tb.sv @@
`timescale 1ns / 1ps

// Drives pixels into the RGB to HSV converter in bursts, stalls the result
// side on its own pattern, and gives the verdict from the checker's count.
module rgb_to_hsv_converter_tb;
   import rth_pkg::*;

   localparam int COLOR_BITS     = DEFAULT_COLOR_BITS;
   localparam int HUE_FRAC_BITS  = DEFAULT_HUE_FRAC_BITS;
   localparam int HUE_W          = 9 + HUE_FRAC_BITS;
   localparam int REQ_W          = ((3 * COLOR_BITS + 7) / 8) * 8;
   localparam int RSP_W          = ((HUE_W + 2 * COLOR_BITS + 7) / 8) * 8;
   localparam int MAX_C          = (1 << COLOR_BITS) - 1;
   localparam int RANDOM_PIXELS  = 1600;
   localparam int TAIL_CYCLES    = 40;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum logic [1:0] {
      RX_OPEN    = 2'd0,
      RX_BUSY    = 2'd1,
      RX_SPARSE  = 2'd2,
      RX_BLOCKED = 2'd3
   } rx_mode_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;   // red, green, blue
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;   // hue, saturation, brightness

   int          fail_count;
   int          pending;
   int          pixels_seen;
   int          results_seen;
   int          burst_left;
   int          rx_left;
   int          idle_cycles;
   rx_mode_type rx_mode;

   rgb_to_hsv_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   rgb_to_hsv_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fail_count   (fail_count),
      .pending      (pending),
      .pixels_seen  (pixels_seen),
      .results_seen (results_seen)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Send one pixel; bursts of random length separated by random gaps
   task automatic send_pixel(input int red, input int green, input int blue);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                   : $urandom_range(1, 40);
      end
      req_tvalid = 1'b1;
      req_tdata  = '0;
      req_tdata[3*COLOR_BITS-1:0] = {blue[COLOR_BITS-1:0], green[COLOR_BITS-1:0],
                                     red[COLOR_BITS-1:0]};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      burst_left--;
      @(negedge clock);
   endtask

   // Random pixel biased toward greys, ties, dark and saturated corners
   task automatic send_random_pixel();
      int kind;
      int a;
      int b;
      int c;
      kind = $urandom_range(0, 9);
      a = $urandom_range(0, MAX_C);
      b = $urandom_range(0, MAX_C);
      c = $urandom_range(0, MAX_C);
      case (kind)
         5: send_pixel(a, a, a);
         6: begin
            // two equal tops, third at or below
            c = $urandom_range(0, a);
            case ($urandom_range(0, 2))
               0:       send_pixel(a, a, c);
               1:       send_pixel(c, a, a);
               default: send_pixel(a, c, a);
            endcase
         end
         7: send_pixel($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
         8: begin
            case ($urandom_range(0, 2))
               0:       send_pixel(MAX_C, b, c);
               1:       send_pixel(a, MAX_C, c);
               default: send_pixel(a, b, MAX_C);
            endcase
         end
         9: begin
            case ($urandom_range(0, 2))
               0:       send_pixel(0, b, c);
               1:       send_pixel(a, 0, c);
               default: send_pixel(a, b, 0);
            endcase
         end
         default: send_pixel(a, b, c);
      endcase
   endtask

   // Result side stalls on its own changing pattern
   initial begin
      rsp_tready = 1'b0;
      rx_mode    = RX_OPEN;
      rx_left    = 0;
      forever begin
         @(negedge clock);
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 150);
         end
         rx_left--;
         case (rx_mode)
            RX_OPEN:    rsp_tready = 1'b1;
            RX_BUSY:    rsp_tready = ($urandom_range(0, 3) != 0);
            RX_SPARSE:  rsp_tready = ($urandom_range(0, 3) == 0);
            RX_BLOCKED: rsp_tready = (rx_left % 32 == 0);
            default:    rsp_tready = 1'b1;
         endcase
      end
   end

   // Watchdog: too long with no item moving on either side
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("[rgb_to_hsv_converter] ERROR");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      burst_left = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // black, white, mid grey
      send_pixel(0, 0, 0);
      send_pixel(MAX_C, MAX_C, MAX_C);
      send_pixel(128, 128, 128);
      // primaries and secondaries
      send_pixel(MAX_C, 0, 0);
      send_pixel(0, MAX_C, 0);
      send_pixel(0, 0, MAX_C);
      send_pixel(MAX_C, MAX_C, 0);
      send_pixel(0, MAX_C, MAX_C);
      send_pixel(MAX_C, 0, MAX_C);
      // ties for the largest component
      send_pixel(200, 200, 10);
      send_pixel(10, 200, 200);
      send_pixel(200, 10, 200);
      // red largest with blue above green (negative hue wraps) or equal to it
      send_pixel(MAX_C, 0, 1);
      send_pixel(MAX_C, 100, 101);
      send_pixel(MAX_C, 7, 7);
      // smallest nonzero value and chroma
      send_pixel(1, 0, 0);
      send_pixel(0, 0, 1);
      send_pixel(1, 1, 0);
      send_pixel(MAX_C, MAX_C - 1, MAX_C - 1);
      send_pixel(MAX_C - 1, MAX_C, MAX_C - 1);
      // one-step differences around each sextant, then one mixed colour
      send_pixel(MAX_C, 1, 0);
      send_pixel(1, MAX_C, 0);
      send_pixel(0, 1, MAX_C);
      send_pixel(8'hAA, 8'h55, 8'hFF);

      repeat (RANDOM_PIXELS) send_random_pixel();

      req_tvalid = 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d pixels sent, %0d results checked", pixels_seen, results_seen);
      $display("covered: corners, greys, ties, hue wrap, random sextants under stalls");
      if (fail_count == 0) begin
         $display("[rgb_to_hsv_converter] OK");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("[rgb_to_hsv_converter] ERROR");
      end
      $finish;
   end

endmodule
